FILE: hdl/dnle_pkg.sv
// dnle_pkg: shared types and constants of the dns name label encoder
// used by dnle_front, dnle_back, the top level and the checker; no dependencies

package dnle_pkg;

  // label limits
  localparam int MAX_LABEL   = 63;
  localparam int STORE_DEPTH = 63;
  localparam int CNT_W       = 6;

  // character that closes a label
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // kind of work the back part carries out for one item
  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_DOT   = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

  // back part sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LEN  = 2'd1,
    ST_RD   = 2'd2,
    ST_CH   = 2'd3
  } back_state_t;

  // one encoded result item
  typedef struct packed {
    logic       too_long;
    logic       term;
    logic       last;
    logic [7:0] data;
  } result_t;

endpackage

FILE: hdl/dns_name_label_encoder_unit.sv
// dns_name_label_encoder_unit: top level of the dns name label encoder
// depends on dnle_pkg, dnle_front and dnle_back

// Encodes a dotted host name, fed one character per item, into DNS wire
// format. Characters other than a dot are stored; a dot emits the label's
// length byte followed by its characters (tlast on the last byte of the item);
// an item with s_tuser set emits the zero terminator and drops any characters
// stored since the last dot. Labels beyond 63 characters are cut to 63 and
// flagged on their length byte. An item enters a two-entry command queue;
// the back end stores a plain character, emits the terminator for an end
// item, and for a dot emits the length byte and then each stored character,
// which is read through the store's registered read port before it is loaded
// into the output register. The queue takes new items while the back end
// emits a label, until both entries are full; output back-pressure stalls it.

module dns_name_label_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tuser,   // [0] name_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] is_terminator, [1] label_too_long
);

  logic               cmd_valid;
  logic               cmd_ready;
  dnle_pkg::cmd_t     cmd;
  dnle_pkg::result_t  res;

  // item intake and classification
  dnle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .name_end  (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // label store and emission
  dnle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = res.data;
  assign m_tlast = res.last;
  assign m_tuser = {res.too_long, res.term};

endmodule

FILE: hdl/dnle_front.sv
// dnle_front: accepts input items, classifies them and queues commands
// depends on dnle_pkg

module dnle_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char,
  input  logic          name_end,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output dnle_pkg::cmd_t cmd
);

  dnle_pkg::cmd_t                  queue [dnle_pkg::QUEUE_DEPTH];
  logic [dnle_pkg::QPTR_W-1:0]     wr_ptr;
  logic [dnle_pkg::QPTR_W-1:0]     rd_ptr;
  logic [dnle_pkg::QPTR_W:0]       fill;
  dnle_pkg::cmd_t                  cmd_in;
  logic                            push;
  logic                            pop;

  // classify the incoming item
  always_comb begin
    cmd_in.ch = in_char;
    if (name_end) begin
      cmd_in.kind = dnle_pkg::CMD_END;
    end else if (in_char == dnle_pkg::DOT_CHAR) begin
      cmd_in.kind = dnle_pkg::CMD_DOT;
    end else begin
      cmd_in.kind = dnle_pkg::CMD_STORE;
    end
  end

  assign in_ready  = (fill != (dnle_pkg::QPTR_W+1)'(dnle_pkg::QUEUE_DEPTH));
  assign cmd_valid = (fill != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cmd_in;
  end

endmodule

FILE: hdl/dnle_back.sv
// dnle_back: label store, read-out sequencer and output register
// depends on dnle_pkg

module dnle_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dnle_pkg::cmd_t      cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output dnle_pkg::result_t   res
);

  logic [7:0]                  label_store [dnle_pkg::STORE_DEPTH];
  logic [7:0]                  rd_data;
  logic [dnle_pkg::CNT_W-1:0]  label_count;
  logic                        label_overflow;
  logic [dnle_pkg::CNT_W-1:0]  idx;
  dnle_pkg::back_state_t       state;
  dnle_pkg::back_state_t       state_next;
  dnle_pkg::result_t           res_next;
  logic                        out_free;
  logic                        out_load;
  logic                        store_we;
  logic                        set_ovf;
  logic                        clr_label;
  logic                        idx_clr;
  logic                        idx_inc;
  logic                        ch_last;
  logic                        full;

  assign out_free = !res_valid || res_ready;
  assign full     = (label_count == dnle_pkg::CNT_W'(dnle_pkg::MAX_LABEL));
  assign ch_last  = (({1'b0, idx} + 7'd1) == {1'b0, label_count});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dnle_pkg::ST_IDLE: begin
        if (cmd_valid && cmd.kind == dnle_pkg::CMD_DOT) state_next = dnle_pkg::ST_LEN;
      end
      dnle_pkg::ST_LEN: begin
        if (out_free) begin
          state_next = (label_count == '0) ? dnle_pkg::ST_IDLE : dnle_pkg::ST_RD;
        end
      end
      dnle_pkg::ST_RD: begin
        state_next = dnle_pkg::ST_CH;
      end
      dnle_pkg::ST_CH: begin
        if (out_free) state_next = ch_last ? dnle_pkg::ST_IDLE : dnle_pkg::ST_RD;
      end
      default: state_next = dnle_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready = 1'b0;
    store_we  = 1'b0;
    set_ovf   = 1'b0;
    clr_label = 1'b0;
    out_load  = 1'b0;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    res_next  = '0;
    case (state)
      dnle_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            dnle_pkg::CMD_STORE: begin
              cmd_ready = 1'b1;
              store_we  = !full;
              set_ovf   = full;
            end
            dnle_pkg::CMD_DOT: begin
              cmd_ready = 1'b1;
            end
            dnle_pkg::CMD_END: begin
              if (out_free) begin
                cmd_ready     = 1'b1;
                out_load      = 1'b1;
                clr_label     = 1'b1;
                res_next.last = 1'b1;
                res_next.term = 1'b1;
              end
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      dnle_pkg::ST_LEN: begin
        if (out_free) begin
          out_load          = 1'b1;
          idx_clr           = 1'b1;
          res_next.data     = {{(8-dnle_pkg::CNT_W){1'b0}}, label_count};
          res_next.last     = (label_count == '0);
          res_next.too_long = label_overflow;
          clr_label         = (label_count == '0);
        end
      end
      dnle_pkg::ST_CH: begin
        if (out_free) begin
          out_load      = 1'b1;
          idx_inc       = 1'b1;
          res_next.data = rd_data;
          res_next.last = ch_last;
          clr_label     = ch_last;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dnle_pkg::ST_IDLE;
      label_count    <= '0;
      label_overflow <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_label) begin
        label_count    <= '0;
        label_overflow <= 1'b0;
      end else begin
        if (store_we) label_count <= label_count + 1'b1;
        if (set_ovf)  label_overflow <= 1'b1;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // read index and output payload
  always_ff @(posedge clk) begin
    if (idx_clr) begin
      idx <= '0;
    end else if (idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (out_load) res <= res_next;
  end

  // label store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (store_we) label_store[label_count] <= cmd.ch;
    rd_data <= label_store[idx];
  end

endmodule

FILE: hdl/dnle_checker.sv
// dnle_checker: port-level assertions for dns_name_label_encoder_unit
// depends on dnle_pkg; bound to the top level at the end of this file

module dnle_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // a stalled output item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output item changed while stalled");

  // terminator is a zero byte closing its item, never flagged too long
  a_term: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 8'd0 && m_tlast && !m_tuser[1])
    else $error("malformed terminator");

  // too-long flag only on a length byte holding the maximum
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == 8'(dnle_pkg::MAX_LABEL) && !m_tuser[0])
    else $error("too-long flag on a wrong byte");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind dns_name_label_encoder_unit dnle_checker u_dnle_checker (.*);
